@@ sv/wams_pkg.sv @@
// Shared types and constants for the weighted adjacency matrix store.
// Used by the front, the queue, the back and the top level.
// Depends on nothing.
package wams_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int WEIGHT_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH      = 2;
  localparam int VTX_BITS         = 6;
  localparam int CNT_BITS         = 7;
  localparam int WOUT_BITS        = 16;

  localparam logic [CNT_BITS-1:0] VCOUNT_RESET = 7'd64;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_LIST  = 2'd2;

  localparam logic KIND_QUERY = 1'b0;
  localparam logic KIND_LIST  = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_QUERY,
    OP_LIST
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE2,
    ST_ANSWER,
    ST_CHECK,
    ST_FINISH
  } back_state_t;

  typedef struct packed {
    logic [1:0]                  func;
    logic [VTX_BITS-1:0]         first_vertex;
    logic [VTX_BITS-1:0]         second_vertex;
    logic signed [WOUT_BITS-1:0] edge_weight;
  } cmd_t;

  typedef struct packed {
    logic                        kind;
    logic [VTX_BITS-1:0]         neighbour;
    logic signed [WOUT_BITS-1:0] weight_out;
    logic                        present;
    logic                        last;
  } rsp_t;

  // One classified operation as it waits between front and back.
  typedef struct packed {
    op_t                  op;
    logic                 ok;
    logic [VTX_BITS-1:0]  a;
    logic [VTX_BITS-1:0]  b;
    logic [WOUT_BITS-1:0] weight;
    logic [CNT_BITS-1:0]  lim;
  } op_entry_t;

endpackage

@@ sv/wams_chan_if.sv @@
// Valid/ready channel interface carrying one payload item per handshake.
// The payload type is a parameter; the block uses wams_pkg::cmd_t and wams_pkg::rsp_t.
interface wams_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ sv/wams_front.sv @@
// Front part: accepts command items, range-checks them and classifies them into ops.
// Depends on wams_pkg and wams_chan_if.
module wams_front #(
  parameter int MAX_VERTICES = wams_pkg::MAX_VERTICES_DEF
) (
  wams_chan_if.sink                        cmd,
  input  logic [wams_pkg::CNT_BITS-1:0]    vertex_count,
  input  logic                             q_full,
  input  logic                             clearing,
  output logic                             push,
  output wams_pkg::op_entry_t              push_data
);

  localparam logic [wams_pkg::CNT_BITS-1:0] MAX_CNT = wams_pkg::CNT_BITS'(MAX_VERTICES);

  logic [wams_pkg::CNT_BITS-1:0] lim;
  logic                          a_ok;
  logic                          b_ok;
  logic                          keep;

  assign lim  = (vertex_count > MAX_CNT) ? MAX_CNT : vertex_count;
  assign a_ok = {1'b0, cmd.data.first_vertex} < lim;
  assign b_ok = {1'b0, cmd.data.second_vertex} < lim;

  assign cmd.ready = !q_full && !clearing;

  always_comb begin
    push_data.a      = cmd.data.first_vertex;
    push_data.b      = cmd.data.second_vertex;
    push_data.weight = cmd.data.edge_weight;
    push_data.lim    = lim;
    push_data.ok     = a_ok && b_ok;
    push_data.op     = wams_pkg::OP_WRITE;
    keep             = 1'b0;
    unique case (cmd.data.func)
      wams_pkg::FUNC_WRITE: begin
        // drop writes that touch an out-of-range vertex
        keep = a_ok && b_ok;
      end
      wams_pkg::FUNC_QUERY: begin
        push_data.op = wams_pkg::OP_QUERY;
        keep         = 1'b1;
      end
      wams_pkg::FUNC_LIST: begin
        push_data.op = wams_pkg::OP_LIST;
        push_data.ok = a_ok;
        keep         = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = cmd.valid && cmd.ready && keep;

endmodule

@@ sv/wams_fifo.sv @@
// Short queue of classified ops between the front and the back.
// Depends on wams_pkg.
module wams_fifo #(
  parameter int DEPTH = wams_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  wams_pkg::op_entry_t push_data,
  input  logic                pop,
  output wams_pkg::op_entry_t head,
  output logic                empty,
  output logic                full
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  wams_pkg::op_entry_t entries [DEPTH];
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr;
  logic [CW-1:0]       count;

  assign head  = entries[rd_ptr];
  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ sv/wams_back.sv @@
// Back part: weight memory with its clearing sweep, op sequencer and result register.
// Depends on wams_pkg and wams_chan_if.
module wams_back #(
  parameter int MAX_VERTICES = wams_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = wams_pkg::WEIGHT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  wams_pkg::op_entry_t head,
  input  logic                empty,
  output logic                pop,
  output logic                clearing,
  wams_chan_if.source         rsp
);

  localparam int VB    = $clog2(MAX_VERTICES);
  localparam int AB    = 2 * VB;
  localparam int DEPTH = 1 << AB;
  localparam int CB    = wams_pkg::CNT_BITS;
  localparam int OB    = wams_pkg::WOUT_BITS;

  logic [WEIGHT_BITS-1:0] mem [DEPTH];

  wams_pkg::back_state_t  state;
  wams_pkg::back_state_t  state_next;
  wams_pkg::op_entry_t    cur;
  logic [AB-1:0]          clr_addr;
  logic [WEIGHT_BITS-1:0] rd_data;
  logic [VB-1:0]          col;
  logic                   pend_vld;
  logic [VB-1:0]          pend_col;
  logic [OB-1:0]          pend_w;
  logic                   out_valid;
  wams_pkg::rsp_t         out_data;

  logic                   we;
  logic [AB-1:0]          waddr;
  logic [WEIGHT_BITS-1:0] wdata;
  logic [WEIGHT_BITS-1:0] wconv;
  logic [OB-1:0]          wsrc;
  logic                   re;
  logic [AB-1:0]          raddr;
  logic                   load;
  wams_pkg::rsp_t         load_data;
  logic                   pend_set;
  logic                   pend_clr;
  logic                   col_zero;
  logic                   col_inc;
  logic                   out_free;
  logic [OB-1:0]          rd_w16;
  logic                   rd_nz;
  logic                   at_end;
  logic [VB-1:0]          col_plus;
  logic [VB-1:0]          ha;
  logic [VB-1:0]          hb;
  logic [VB-1:0]          ca;
  logic [VB-1:0]          cb;

  assign ha       = head.a[VB-1:0];
  assign hb       = head.b[VB-1:0];
  assign ca       = cur.a[VB-1:0];
  assign cb       = cur.b[VB-1:0];
  assign col_plus = col + VB'(1);
  assign at_end   = (CB'(col) + CB'(1)) == cur.lim;
  assign rd_nz    = (rd_data != '0);
  assign out_free = !out_valid || rsp.ready;
  assign clearing = (state == wams_pkg::ST_CLEAR);

  // weight source: the head op on the first write, the held op on the mirror write
  assign wsrc = (state == wams_pkg::ST_IDLE) ? head.weight : cur.weight;

  generate
    if (WEIGHT_BITS <= OB) begin : g_wr_narrow
      assign wconv = wsrc[WEIGHT_BITS-1:0];
    end else begin : g_wr_wide
      assign wconv = {{(WEIGHT_BITS - OB){wsrc[OB-1]}}, wsrc};
    end
    if (WEIGHT_BITS >= OB) begin : g_rd_wide
      assign rd_w16 = rd_data[OB-1:0];
    end else begin : g_rd_narrow
      assign rd_w16 = {{(OB - WEIGHT_BITS){rd_data[WEIGHT_BITS-1]}}, rd_data};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_data <= mem[raddr];
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    we         = 1'b0;
    waddr      = {ca, cb};
    wdata      = wconv;
    re         = 1'b0;
    raddr      = {ca, col_plus};
    load       = 1'b0;
    load_data  = '0;
    pend_set   = 1'b0;
    pend_clr   = 1'b0;
    col_zero   = 1'b0;
    col_inc    = 1'b0;
    unique case (state)
      wams_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
        if (clr_addr == '1) begin
          state_next = wams_pkg::ST_IDLE;
        end
      end
      wams_pkg::ST_IDLE: begin
        if (!empty) begin
          pop = 1'b1;
          unique case (head.op)
            wams_pkg::OP_WRITE: begin
              we         = 1'b1;
              waddr      = {ha, hb};
              state_next = wams_pkg::ST_WRITE2;
            end
            wams_pkg::OP_QUERY: begin
              re         = 1'b1;
              raddr      = {ha, hb};
              state_next = wams_pkg::ST_ANSWER;
            end
            wams_pkg::OP_LIST: begin
              if (head.ok) begin
                re         = 1'b1;
                raddr      = {ha, {VB{1'b0}}};
                col_zero   = 1'b1;
                state_next = wams_pkg::ST_CHECK;
              end else begin
                state_next = wams_pkg::ST_ANSWER;
              end
            end
            default: begin
              state_next = wams_pkg::ST_IDLE;
            end
          endcase
        end
      end
      wams_pkg::ST_WRITE2: begin
        // mirror entry; same address again on the diagonal
        we         = 1'b1;
        waddr      = {cb, ca};
        state_next = wams_pkg::ST_IDLE;
      end
      wams_pkg::ST_ANSWER: begin
        if (out_free) begin
          load           = 1'b1;
          load_data.last = 1'b1;
          if (cur.op == wams_pkg::OP_QUERY) begin
            load_data.kind       = wams_pkg::KIND_QUERY;
            load_data.weight_out = cur.ok ? rd_w16 : '0;
            load_data.present    = cur.ok && rd_nz;
          end else begin
            load_data.kind = wams_pkg::KIND_LIST;
          end
          state_next = wams_pkg::ST_IDLE;
        end
      end
      wams_pkg::ST_CHECK: begin
        // hold the read data while a pending entry cannot be handed on
        if (!(rd_nz && pend_vld) || out_free) begin
          if (rd_nz && pend_vld) begin
            load                 = 1'b1;
            load_data.kind       = wams_pkg::KIND_LIST;
            load_data.neighbour  = wams_pkg::VTX_BITS'(pend_col);
            load_data.weight_out = pend_w;
            load_data.present    = 1'b1;
          end
          pend_set = rd_nz;
          if (at_end) begin
            state_next = wams_pkg::ST_FINISH;
          end else begin
            re      = 1'b1;
            col_inc = 1'b1;
          end
        end
      end
      wams_pkg::ST_FINISH: begin
        if (out_free) begin
          load           = 1'b1;
          load_data.kind = wams_pkg::KIND_LIST;
          load_data.last = 1'b1;
          if (pend_vld) begin
            load_data.neighbour  = wams_pkg::VTX_BITS'(pend_col);
            load_data.weight_out = pend_w;
            load_data.present    = 1'b1;
          end
          pend_clr   = 1'b1;
          state_next = wams_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wams_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wams_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      pend_vld  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + AB'(1);
      end
      if (pend_clr) begin
        pend_vld <= 1'b0;
      end else if (pend_set) begin
        pend_vld <= 1'b1;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (col_zero) begin
      col <= '0;
    end else if (col_inc) begin
      col <= col_plus;
    end
    if (pend_set) begin
      pend_col <= col;
      pend_w   <= rd_w16;
    end
    if (load) begin
      out_data <= load_data;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!out_valid || rsp.ready))
    else $error("result register loaded while a result is still waiting");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == wams_pkg::ST_IDLE) |-> !pend_vld)
    else $error("neighbour entry left pending after a row scan");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == wams_pkg::ST_CHECK) |-> (CB'(col) < cur.lim))
    else $error("row scan column beyond vertex count");

  a_mirror_follows_pop: assert property (@(posedge clk) disable iff (rst)
    (state == wams_pkg::ST_WRITE2) |-> $past(pop))
    else $error("mirror write without a preceding write op");

endmodule

@@ sv/weighted_adjacency_matrix_store.sv @@
// Top level of the symmetric weighted adjacency matrix store.
// Depends on wams_pkg, wams_chan_if, wams_front, wams_fifo and wams_back.
//
// Usage:
//   cmd carries command items (func, first_vertex, second_vertex, edge_weight);
//   rsp carries result items (kind, neighbour, weight_out, present, last).
//   Both are valid/ready channels; an item moves when valid and ready are high
//   at a rising edge. cfg_write/cfg_data load vertex_count (reset 64); write it
//   only while the block is idle.
// Reset: rst (synchronous) starts a sweep that zeroes the weight memory one
//   entry per cycle over all 2**(2*ceil(log2(MAX_VERTICES))) entries (4096 by default).
//   cmd.ready stays low during the sweep.
// Flow: the front classifies an item in the cycle it is taken and drops
//   unused codes and out-of-range writes; a two-entry queue feeds the back.
//   The back owns the weight memory and handles one op at a time:
//   a write puts the pair entry and then the mirror entry, a query reads
//   and then answers, a neighbour list reads the row's entries in use one by one.
//   A query result passes the queue, the memory read and the result register.
// Stall: results wait in an output register; while rsp is stalled the back
//   holds, the queue fills and then cmd.ready drops.
module weighted_adjacency_matrix_store #(
  parameter int MAX_VERTICES = wams_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = wams_pkg::WEIGHT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [wams_pkg::CNT_BITS-1:0] cfg_data,
  wams_chan_if.sink                     cmd,
  wams_chan_if.source                   rsp
);

  logic [wams_pkg::CNT_BITS-1:0] vertex_count;
  logic                          push;
  wams_pkg::op_entry_t           push_data;
  wams_pkg::op_entry_t           head;
  logic                          pop;
  logic                          empty;
  logic                          full;
  logic                          clearing;

  // vertex count register; the user must write it only while no item is in flight, the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= wams_pkg::VCOUNT_RESET;
    end else if (cfg_write) begin
      vertex_count <= cfg_data;
    end
  end

  // accept and classify
  wams_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .cmd          (cmd),
    .vertex_count (vertex_count),
    .q_full       (full),
    .clearing     (clearing),
    .push         (push),
    .push_data    (push_data)
  );

  // decouple front and back
  wams_fifo #(
    .DEPTH (wams_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  // memory, sequencing and result register
  wams_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .empty    (empty),
    .pop      (pop),
    .clearing (clearing),
    .rsp      (rsp)
  );

endmodule
